/* design/bceq_pkg.sv */
// Shared types, constants and key code decoder for the button change event queue.
package bceq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int BUTTON_COUNT_DEF = 12;
  localparam int BTN_W            = 12;
  localparam int KEY_W            = 8;
  localparam int BTN_IDX_W        = 5;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [BTN_W-1:0] buttons;
  } bceq_in_t;

  typedef struct packed {
    logic             event_valid;
    logic             event_pressed;
    logic [KEY_W-1:0] event_key;
  } bceq_out_t;

  typedef struct packed {
    logic             pressed;
    logic [KEY_W-1:0] key;
  } bceq_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP
  } bceq_state_t;

  typedef struct packed {
    logic take_sample;
    logic scan_step;
    logic take_pop;
    logic load_out;
  } bceq_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } bceq_sts_t;

  // Fixed key code per button position; positions past the table map to zero.
  function automatic logic [KEY_W-1:0] key_code(input logic [BTN_IDX_W-1:0] idx);
    logic [KEY_W-1:0] k;
    unique case (idx)
      5'd0:    k = 8'hAD;
      5'd1:    k = 8'hAF;
      5'd2:    k = 8'hAC;
      5'd3:    k = 8'hAE;
      5'd4:    k = 8'hA3;
      5'd5:    k = 8'hA2;
      5'd6:    k = 8'hB6;
      5'd7:    k = 8'h0D;
      5'd8:    k = 8'h78;
      5'd9:    k = 8'h79;
      5'd10:   k = 8'h7A;
      5'd11:   k = 8'h09;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

/* design/bceq_ctrl.sv */
// Controller state machine: sequences sample scans and pops.
module bceq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_operation,
  output logic                in_ready,
  input  bceq_pkg::bceq_sts_t sts,
  output bceq_pkg::bceq_cmd_t cmd
);

  bceq_pkg::bceq_state_t state_r;
  bceq_pkg::bceq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bceq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bceq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == bceq_pkg::OP_POP) begin
            state_nxt = bceq_pkg::ST_POP;
          end else begin
            state_nxt = bceq_pkg::ST_SCAN;
          end
        end
      end
      bceq_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = bceq_pkg::ST_IDLE;
        end
      end
      bceq_pkg::ST_POP: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          state_nxt = bceq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bceq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.take_sample = 1'b0;
    cmd.take_pop    = 1'b0;
    cmd.scan_step   = 1'b0;
    cmd.load_out    = 1'b0;
    unique case (state_r)
      bceq_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.take_sample = in_valid && (in_operation == bceq_pkg::OP_SAMPLE);
        cmd.take_pop    = in_valid && (in_operation == bceq_pkg::OP_POP);
      end
      bceq_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      bceq_pkg::ST_POP: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* design/bceq_dp.sv */
// Datapath: button history, change scan, event ring and output register.
module bceq_dp #(
  parameter int QUEUE_DEPTH  = bceq_pkg::QUEUE_DEPTH_DEF,
  parameter int BUTTON_COUNT = bceq_pkg::BUTTON_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bceq_pkg::bceq_in_t  in_data,
  input  bceq_pkg::bceq_cmd_t cmd,
  output bceq_pkg::bceq_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output bceq_pkg::bceq_out_t out_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int IDXW  = bceq_pkg::BTN_IDX_W;

  bceq_pkg::bceq_entry_t mem [QUEUE_DEPTH];
  bceq_pkg::bceq_entry_t rd_data_r;

  logic [BUTTON_COUNT-1:0] prev_r, prev_nxt;
  logic [BUTTON_COUNT-1:0] diff_r, diff_nxt;
  logic [CNT_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic                    empty_r, empty_nxt;
  logic                    out_valid_r, out_valid_nxt;
  bceq_pkg::bceq_out_t     out_data_r, out_data_nxt;

  logic                    push;
  logic                    ring_empty;
  bceq_pkg::bceq_entry_t   wr_entry;

  assign ring_empty = (rd_ptr_r == wr_ptr_r);
  assign push       = cmd.scan_step && diff_r[scan_idx_r];

  assign wr_entry.pressed = prev_r[scan_idx_r];
  assign wr_entry.key     = bceq_pkg::key_code(IDXW'(scan_idx_r));

  assign sts.scan_last = (scan_idx_r == CNT_W'(BUTTON_COUNT - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    prev_nxt     = prev_r;
    diff_nxt     = diff_r;
    scan_idx_nxt = scan_idx_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    empty_nxt    = empty_r;

    if (cmd.take_sample) begin
      prev_nxt     = BUTTON_COUNT'(in_data.buttons);
      diff_nxt     = BUTTON_COUNT'(in_data.buttons) ^ prev_r;
      scan_idx_nxt = '0;
    end

    if (cmd.scan_step) begin
      scan_idx_nxt = scan_idx_r + CNT_W'(1);
    end

    // advance with no full check: an overrun drops older events
    if (push) begin
      if (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
      end
    end

    if (cmd.take_pop) begin
      empty_nxt = ring_empty;
      if (!ring_empty) begin
        if (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) begin
          rd_ptr_nxt = '0;
        end else begin
          rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.load_out) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.event_valid   = !empty_r;
      out_data_nxt.event_pressed = empty_r ? 1'b0 : rd_data_r.pressed;
      out_data_nxt.event_key     = empty_r ? '0 : rd_data_r.key;
    end else if (out_ready) begin
      // drop the result once its transfer completes
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r     <= diff_nxt;
    empty_r    <= empty_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  a_empty_pop_holds_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_pop && ring_empty) |=> $stable(rd_ptr_r))
    else $error("read pointer moved on a pop from an empty ring");

  a_wr_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.scan_step |=> $stable(wr_ptr_r))
    else $error("write pointer moved outside a scan");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.event_valid) |->
      (out_data_r.event_pressed == 1'b0 && out_data_r.event_key == '0))
    else $error("empty-ring result carries a non-zero event");

  a_load_sets_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_valid_r && (out_data_r.event_valid == !$past(empty_r))))
    else $error("loaded result does not match the pop outcome");

endmodule

/* design/button_change_event_queue.sv */
// Sample item: transfer cycle, then a scan of BUTTON_COUNT buttons, one button per cycle,
//   after which the next item is taken; no result.
// Pop item: the entry is read into the read register, then ST_POP loads the result
//   into the output register once it is free; the next item is taken after that load.
// Event ring is one write port and one registered read port of QUEUE_DEPTH entries.
// Reset (synchronous, rst_n low): pointers, button history, state and out_valid clear;
//   ring contents are not cleared and have no meaning until written.
module button_change_event_queue #(
  parameter int QUEUE_DEPTH  = bceq_pkg::QUEUE_DEPTH_DEF,
  parameter int BUTTON_COUNT = bceq_pkg::BUTTON_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bceq_pkg::bceq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bceq_pkg::bceq_out_t out_data
);

  bceq_pkg::bceq_cmd_t cmd;
  bceq_pkg::bceq_sts_t sts;

  bceq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_data.operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  bceq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
